/* rtl/fpsa_pkg.sv */
// shared constants and helpers for the five point stencil average block
`default_nettype none

package fpsa_pkg;

  // cell values: unsigned, 8 fraction bits
  localparam int unsigned VALUE_W = 48;

  // configuration port
  localparam int unsigned ROWS_CFG_W = 13;
  localparam int unsigned COLS_CFG_W = 11;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

  localparam int unsigned GRID_ROWS_RESET = 20;
  localparam int unsigned GRID_COLS_RESET = 30;
  localparam int unsigned GRID_MIN        = 3;

  // sum of five values and its split for the two step divide by five
  localparam int unsigned SUM_W   = VALUE_W + 3;
  localparam int unsigned SPLIT_W = 24;
  localparam int unsigned HI_W    = SUM_W - SPLIT_W;
  localparam int unsigned QH_W    = VALUE_W - SPLIT_W;

  // x / 5 == (x * DIV5_MUL) >> DIV5_SHIFT for every x below 2**32
  localparam int unsigned DIV5_MUL_W = 32;
  localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 32'hCCCC_CCCD;
  localparam int unsigned DIV5_SHIFT = 34;

  function automatic int unsigned clamp_u(input int unsigned v, input int unsigned lo,
                                          input int unsigned hi);
    int unsigned r;
    r = v;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/five_point_stencil_average.sv */
// five point stencil average over a raster stream of grid cells
//
// usage
// - s_axis carries one grid cell per transfer in raster order; tuser marks the
//   first cell of a frame and restarts the position counters
// - m_axis carries one result per interior cell: its position, the mean of the
//   cell and its four neighbours (sum / 5, truncated) and tlast on the last
//   interior result of the frame
// - cfg_we_i writes grid_rows (index 0) or grid_cols (index 1); values are
//   clamped to the supported range, write only while the stream is idle
// - the result of cell (r,c) is computed when cell (r+1,c) is transferred and
//   is then registered through stages 2, 3 and 4 into the output register
// - throughput is one cell per cycle unless m_axis stalls: the previous rows live
//   in two banked line stores (even and odd columns), each with one read and one
//   write port, so the cell above and its right neighbour are read in the same cycle
// - a write-back to an entry that is read in the same cycle is forwarded
// - reset clears the counters and the pipeline and sets a 20 x 30 grid; the
//   line stores are not cleared, stale entries only feed edge rows
// - while the output register is full and m_axis_tready_i is low, the whole
//   pipeline holds and s_axis_tready_o is low
`default_nettype none

module five_point_stencil_average #(
  parameter int unsigned MAX_COLS = 1024,
  parameter int unsigned MAX_ROWS = 4096,
  localparam int unsigned RW = $clog2(MAX_ROWS),
  localparam int unsigned CW = $clog2(MAX_COLS),
  localparam int unsigned OUT_W = RW + CW + fpsa_pkg::VALUE_W,
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration
  input  wire logic                             cfg_we_i,
  input  wire logic [fpsa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [fpsa_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // cell stream
  input  wire logic                             s_axis_tvalid_i,
  output      logic                             s_axis_tready_o,
  input  wire logic [fpsa_pkg::VALUE_W-1:0]     s_axis_tdata_i,  // cell_value
  input  wire logic                             s_axis_tuser_i,  // frame_start
  // result stream
  output      logic                             m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  output      logic [OUT_TDATA_W-1:0]           m_axis_tdata_o,  // center_row, center_col,
                                                                 // average, zero pad
  output      logic                             m_axis_tlast_o   // frame_last
);
  import fpsa_pkg::*;

  localparam int unsigned BAW        = CW - 1;
  localparam int unsigned BANK_DEPTH = 1 << BAW;
  localparam int unsigned ENTRY_W    = 2 * VALUE_W;
  localparam int unsigned PROD_W     = HI_W + DIV5_MUL_W;

  localparam logic [RW-1:0] RESET_LAST_ROW =
    RW'(clamp_u(GRID_ROWS_RESET, GRID_MIN, MAX_ROWS) - 1);
  localparam logic [CW-1:0] RESET_LAST_COL =
    CW'(clamp_u(GRID_COLS_RESET, GRID_MIN, MAX_COLS) - 1);

  // position and frame marker that travel with a result
  typedef struct packed {
    logic [RW-1:0] row;
    logic [CW-1:0] col;
    logic          last;
  } tag_t;

  // ---------------------------------------------------------------------------
  // configuration, kept as last row and last column index
  // ---------------------------------------------------------------------------
  logic [RW-1:0] last_row_q, last_row_d;
  logic [CW-1:0] last_col_q, last_col_d;

  always_comb begin
    last_row_d = last_row_q;
    last_col_d = last_col_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRID_ROWS: last_row_d =
          RW'(clamp_u(int'(cfg_data_i[ROWS_CFG_W-1:0]), GRID_MIN, MAX_ROWS) - 1);
        REG_GRID_COLS: last_col_d =
          CW'(clamp_u(int'(cfg_data_i[COLS_CFG_W-1:0]), GRID_MIN, MAX_COLS) - 1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_row_q <= RESET_LAST_ROW;
      last_col_q <= RESET_LAST_COL;
    end else begin
      last_row_q <= last_row_d;
      last_col_q <= last_col_d;
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline advance: everything moves unless a result is stuck at the output
  // ---------------------------------------------------------------------------
  logic out_valid_q;
  logic adv;
  logic acc;

  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign acc             = s_axis_tvalid_i && adv;

  // ---------------------------------------------------------------------------
  // stage 0: position of the incoming cell, line store read
  // ---------------------------------------------------------------------------
  logic [RW-1:0]      row_q, row_d;
  logic [CW-1:0]      col_q, col_d;
  logic               restart;
  logic [RW-1:0]      r0;
  logic [CW-1:0]      c0;
  logic               edge_cell;
  logic [VALUE_W-1:0] v0;
  logic               right_ok0;
  logic               emit0;
  logic               last0;
  logic [BAW-1:0]     half0;
  logic [BAW-1:0]     addr_e;
  logic [BAW-1:0]     addr_o;

  always_comb begin
    restart   = s_axis_tuser_i || (row_q > last_row_q) || (col_q > last_col_q);
    r0        = restart ? '0 : row_q;
    c0        = restart ? '0 : col_q;
    edge_cell = (r0 == '0) || (r0 == last_row_q) || (c0 == '0) || (c0 == last_col_q);
    v0        = edge_cell ? '0 : s_axis_tdata_i;
    right_ok0 = c0 < last_col_q;
    emit0     = (r0 >= RW'(2)) && (c0 != '0) && right_ok0;
    last0     = (r0 == last_row_q) && (c0 == last_col_q - CW'(1));
    // even columns sit in bank e, odd ones in bank o
    half0     = c0[CW-1:1];
    addr_o    = half0;
    addr_e    = c0[0] ? half0 + BAW'(1) : half0;

    if (c0 == last_col_q) begin
      col_d = '0;
      row_d = (r0 == last_row_q) ? '0 : r0 + RW'(1);
    end else begin
      col_d = c0 + CW'(1);
      row_d = r0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (acc) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // ---------------------------------------------------------------------------
  // line stores: entry = {row two above, row above}, one bank per column parity
  // ---------------------------------------------------------------------------
  logic [ENTRY_W-1:0] bank_e [BANK_DEPTH];
  logic [ENTRY_W-1:0] bank_o [BANK_DEPTH];
  logic [ENTRY_W-1:0] rd_e_q;
  logic [ENTRY_W-1:0] rd_o_q;

  logic               wr_en;
  logic               wr_odd;
  logic [BAW-1:0]     wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en && !wr_odd) begin
      bank_e[wr_addr] <= wr_data;
    end
    if (acc) begin
      rd_e_q <= bank_e[addr_e];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && wr_odd) begin
      bank_o[wr_addr] <= wr_data;
    end
    if (acc) begin
      rd_o_q <= bank_o[addr_o];
    end
  end

  // the write-back of the item ahead lands in the same cycle as this read
  logic               fwd_e_q, fwd_o_q;
  logic [ENTRY_W-1:0] fwd_data_q;

  // ---------------------------------------------------------------------------
  // stage 1: gather the five points, write back the line stores
  // ---------------------------------------------------------------------------
  logic               s1_valid_q;
  logic               s1_emit_q;
  logic               s1_right_ok_q;
  logic [VALUE_W-1:0] s1_v_q;
  logic [CW-1:0]      s1_col_q;
  tag_t               s1_tag_q;
  logic [VALUE_W-1:0] left_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_e_q    <= 1'b0;
      fwd_o_q    <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= acc;
      fwd_e_q    <= acc && wr_en && !wr_odd && (addr_e == wr_addr);
      fwd_o_q    <= acc && wr_en && wr_odd && (addr_o == wr_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_emit_q     <= emit0;
      s1_right_ok_q <= right_ok0;
      s1_v_q        <= v0;
      s1_col_q      <= c0;
      s1_tag_q      <= '{row: r0 - RW'(1), col: c0, last: last0};
      fwd_data_q    <= wr_data;
    end
  end

  logic [ENTRY_W-1:0] ent_e, ent_o, ent_own, ent_other;
  logic [VALUE_W-1:0] above1, two1, right1;

  always_comb begin
    ent_e     = fwd_e_q ? fwd_data_q : rd_e_q;
    ent_o     = fwd_o_q ? fwd_data_q : rd_o_q;
    ent_own   = s1_col_q[0] ? ent_o : ent_e;
    ent_other = s1_col_q[0] ? ent_e : ent_o;
    above1    = ent_own[VALUE_W-1:0];
    two1      = ent_own[ENTRY_W-1:VALUE_W];
    right1    = s1_right_ok_q ? ent_other[VALUE_W-1:0] : '0;

    // row above moves down, the new cell becomes the row above
    wr_en   = s1_valid_q && adv;
    wr_odd  = s1_col_q[0];
    wr_addr = s1_col_q[CW-1:1];
    wr_data = {above1, s1_v_q};
  end

  // previous row's value one column to the left
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else if (wr_en) begin
      left_q <= above1;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: partial sums
  // ---------------------------------------------------------------------------
  logic               s2_valid_q;
  logic [VALUE_W:0]   s2_pa_q, s2_pb_q;
  logic [VALUE_W-1:0] s2_pv_q;
  tag_t               s2_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_pa_q  <= {1'b0, above1} + {1'b0, two1};
      s2_pb_q  <= {1'b0, left_q} + {1'b0, right1};
      s2_pv_q  <= s1_v_q;
      s2_tag_q <= s1_tag_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: full sum
  // ---------------------------------------------------------------------------
  logic             s3_valid_q;
  logic [SUM_W-1:0] s3_sum_q;
  tag_t             s3_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_sum_q <= SUM_W'(s2_pa_q) + SUM_W'(s2_pb_q) + SUM_W'(s2_pv_q);
      s3_tag_q <= s2_tag_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: divide the upper part by five, keep the remainder
  // ---------------------------------------------------------------------------
  logic [HI_W-1:0]    hi3;
  logic [PROD_W-1:0]  prod_h;
  logic [QH_W-1:0]    qh3;
  logic [HI_W-1:0]    qh5;
  logic [2:0]         rh3;

  always_comb begin
    hi3    = s3_sum_q[SUM_W-1:SPLIT_W];
    prod_h = PROD_W'(hi3) * PROD_W'(DIV5_MUL);
    qh3    = prod_h[DIV5_SHIFT +: QH_W];
    qh5    = HI_W'({qh3, 2'b00}) + HI_W'(qh3);
    rh3    = 3'(hi3 - qh5);
  end

  logic               s4_valid_q;
  logic [QH_W-1:0]    s4_qh_q;
  logic [2:0]         s4_rh_q;
  logic [SPLIT_W-1:0] s4_lo_q;
  tag_t               s4_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (adv) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_qh_q  <= qh3;
      s4_rh_q  <= rh3;
      s4_lo_q  <= s3_sum_q[SPLIT_W-1:0];
      s4_tag_q <= s3_tag_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: divide remainder and lower part, into the output register
  // ---------------------------------------------------------------------------
  logic [HI_W-1:0]    x4;
  logic [PROD_W-1:0]  prod_l;
  logic [SPLIT_W-1:0] ql4;

  always_comb begin
    x4     = {s4_rh_q, s4_lo_q};
    prod_l = PROD_W'(x4) * PROD_W'(DIV5_MUL);
    ql4    = prod_l[DIV5_SHIFT +: SPLIT_W];
  end

  logic [VALUE_W-1:0] out_avg_q;
  tag_t               out_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s4_valid_q) begin
      out_avg_q <= {s4_qh_q, ql4};
      out_tag_q <= s4_tag_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({out_avg_q, out_tag_q.col, out_tag_q.row});
  assign m_axis_tlast_o  = out_tag_q.last;

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// self-checking testbench for the five point stencil average block
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fpsa_pkg::*;

  // block sizes, passed to the instance so the predictor agrees with it
  localparam int unsigned MAX_COLS    = 1024;
  localparam int unsigned MAX_ROWS    = 4096;
  localparam int unsigned ROW_W       = 12;
  localparam int unsigned COL_W       = 10;
  localparam int unsigned OUT_TDATA_W = 72;

  // result tdata layout, lowest bit first: center_row, center_col, average, zero pad
  localparam int unsigned ROW_LSB = 0;
  localparam int unsigned COL_LSB = ROW_LSB + ROW_W;
  localparam int unsigned AVG_LSB = COL_LSB + COL_W;

  localparam int unsigned STENCIL_DIVISOR = 5;
  localparam int unsigned TOTAL_W         = VALUE_W + 3;

  localparam int unsigned RESET_CYCLES  = 8;
  localparam int unsigned SETTLE_CYCLES = 16;     // pipeline is 5 deep, plus margin
  localparam int unsigned DRAIN_LIMIT   = 20000;  // per drain, well above the long stall
  localparam int unsigned HOLD_CYCLES   = 300;    // long receiver stall
  localparam int unsigned NOISE_PCT     = 2;      // stray frame starts in noisy phases
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic [ROW_W-1:0]   center_row;
    logic [COL_W-1:0]   center_col;
    logic [VALUE_W-1:0] average;
    logic               frame_last;
  } stencil_mean_t;

  typedef enum logic {ROW_WRITE, ROW_CELL} plan_kind_e;

  typedef struct {
    plan_kind_e            kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [VALUE_W-1:0]    value;  // cell value, or register data for a write
    logic                  start;
    logic                  typed;  // expectation written out by hand
    stencil_mean_t         want;
  } plan_row_t;

  typedef enum int unsigned {PACE_SEND_LIGHT, PACE_SEND_HEAVY, PACE_STEADY} pace_e;

  // ---------------------------------------------------------------------------
  // clock, reset and the signals driven into the block
  // ---------------------------------------------------------------------------
  logic clk;
  logic rst_n = 1'b0;

  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic               s_valid = 1'b0;
  logic [VALUE_W-1:0] s_data  = '0;
  logic               s_start = 1'b0;
  logic               m_ready = 1'b0;

  // travels alongside each cell so the checker sees it at the transfer edge
  logic          cell_typed = 1'b0;
  stencil_mean_t cell_want  = '0;

  wire                   s_ready;
  wire                   m_valid;
  wire [OUT_TDATA_W-1:0] m_data;
  wire                   m_last;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  five_point_stencil_average #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),   // cell_value
    .s_axis_tuser_i (s_start),  // frame_start
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),   // center_row, center_col, average, zero pad
    .m_axis_tlast_o (m_last)    // frame_last
  );

  // ---------------------------------------------------------------------------
  // predictor: own copy of the grid registers, line stores and position
  // ---------------------------------------------------------------------------
  logic [ROWS_CFG_W-1:0] grid_rows_q = ROWS_CFG_W'(GRID_ROWS_RESET);
  logic [COLS_CFG_W-1:0] grid_cols_q = COLS_CFG_W'(GRID_COLS_RESET);
  logic [VALUE_W-1:0]    prev_line  [MAX_COLS];  // row above, edges stored as zero
  logic [VALUE_W-1:0]    prev2_line [MAX_COLS];  // row two above
  logic [VALUE_W-1:0]    left_above = '0;        // previous column's value from the row above
  int unsigned           at_row = 0;
  int unsigned           at_col = 0;

  stencil_mean_t expected_means[$];
  stencil_mean_t mean_next, due, seen;
  bit            hit;

  int unsigned failures      = 0;
  int unsigned cells_taken   = 0;
  int unsigned results_taken = 0;
  int unsigned writes_done   = 0;
  int unsigned cycle_count   = 0;

  pace_e       pace_mode   = PACE_SEND_LIGHT;
  int unsigned phase_count = 0;
  bit          hold_req    = 1'b0;

  function automatic int unsigned span(input int unsigned v, input int unsigned lo,
                                       input int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // one cell into the grid; returns 1 when an interior mean falls out
  function automatic bit stencil_take(input logic [VALUE_W-1:0] value, input logic start,
                                      output stencil_mean_t mean);
    int unsigned        rows, cols, r, c;
    logic [VALUE_W-1:0] v, above, two, right, left;
    logic [TOTAL_W-1:0] total5;
    bit                 found;
    rows = span(32'(grid_rows_q), GRID_MIN, MAX_ROWS);
    cols = span(32'(grid_cols_q), GRID_MIN, MAX_COLS);
    mean = '0;
    // an explicit start or a position the shrunken grid no longer holds opens a frame
    if (start || at_row >= rows || at_col >= cols) begin
      at_row = 0;
      at_col = 0;
    end
    r = at_row;
    c = at_col;
    // whatever arrives on the outer edge counts as zero
    v = value;
    if (r == 0 || r == rows - 1 || c == 0 || c == cols - 1) begin
      v = '0;
    end
    above = prev_line[COL_W'(c)];
    two   = prev2_line[COL_W'(c)];
    right = (c + 1 < cols) ? prev_line[COL_W'(c + 1)] : '0;
    left  = left_above;
    found = (r >= 2 && c >= 1 && c <= cols - 2);
    if (found) begin
      total5          = TOTAL_W'(above) + TOTAL_W'(two) + TOTAL_W'(left) +
                        TOTAL_W'(right) + TOTAL_W'(v);
      mean.center_row = ROW_W'(r - 1);
      mean.center_col = COL_W'(c);
      mean.average    = VALUE_W'(total5 / STENCIL_DIVISOR);
      mean.frame_last = (r == rows - 1 && c == cols - 2);
    end
    left_above             = above;
    prev2_line[COL_W'(c)]  = above;
    prev_line[COL_W'(c)]   = v;
    // raster advance, wrapping to a fresh frame after the last cell
    c++;
    if (c >= cols) begin
      c = 0;
      r++;
      if (r >= rows) begin
        r = 0;
      end
    end
    at_row = r;
    at_col = c;
    return found;
  endfunction

  function automatic void match_field(input string name, input logic [VALUE_W-1:0] want,
                                      input logic [VALUE_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // checker: register writes, cell transfers and result transfers, all sampled
  // at the rising edge so they see the values from before the edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_q = ROWS_CFG_W'(GRID_ROWS_RESET);
      grid_cols_q = COLS_CFG_W'(GRID_COLS_RESET);
      left_above  = '0;
      at_row      = 0;
      at_col      = 0;
      for (int unsigned i = 0; i < MAX_COLS; i++) begin
        prev_line[COL_W'(i)]  = '0;
        prev2_line[COL_W'(i)] = '0;
      end
    end else begin
      if (cfg_we) begin
        writes_done++;
        if (cfg_idx == REG_GRID_ROWS) begin
          grid_rows_q = cfg_data[ROWS_CFG_W-1:0];
        end else if (cfg_idx == REG_GRID_COLS) begin
          grid_cols_q = cfg_data[COLS_CFG_W-1:0];
        end
      end
      if (s_valid && s_ready) begin
        cells_taken++;
        hit = stencil_take(s_data, s_start, mean_next);
        // hand-written rows take the place of the predicted mean
        if (cell_typed) begin
          expected_means.push_back(cell_want);
        end else if (hit) begin
          expected_means.push_back(mean_next);
        end
      end
      if (m_valid && m_ready) begin
        results_taken++;
        seen.center_row = m_data[ROW_LSB +: ROW_W];
        seen.center_col = m_data[COL_LSB +: COL_W];
        seen.average    = m_data[AVG_LSB +: VALUE_W];
        seen.frame_last = m_last;
        if (expected_means.size() == 0) begin
          $error("unexpected result transfer: row %0d col %0d average %0h",
                 seen.center_row, seen.center_col, seen.average);
          failures++;
        end else begin
          due = expected_means.pop_front();
          match_field("center_row", VALUE_W'(due.center_row), VALUE_W'(seen.center_row));
          match_field("center_col", VALUE_W'(due.center_col), VALUE_W'(seen.center_col));
          match_field("average", due.average, seen.average);
          match_field("frame_last", VALUE_W'(due.frame_last), VALUE_W'(seen.frame_last));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random back-pressure, plus one long stall on request
  // ---------------------------------------------------------------------------
  function automatic int unsigned gap_pct(input bit sender_side);
    case (pace_mode)
      PACE_SEND_LIGHT: return sender_side ? 24 : 63;
      PACE_SEND_HEAVY: return sender_side ? 63 : 24;
      default:         return 0;
    endcase
  endfunction

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(0, 99) >= gap_pct(1'b0));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------
  function automatic logic [VALUE_W-1:0] draw_cell();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return VALUE_W'($urandom_range(0, 255));
      default: return VALUE_W'({$urandom(), $urandom()});
    endcase
  endfunction

  // offers one cell and returns at the edge of its transfer
  task automatic offer_cell(input logic [VALUE_W-1:0] value, input logic start,
                            input logic typed, input stencil_mean_t want);
    while ($urandom_range(0, 99) < gap_pct(1'b1)) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid    <= 1'b1;
    s_data     <= value;
    s_start    <= start;
    cell_typed <= typed;
    cell_want  <= want;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
  endtask

  // stop offering, wait for every expected result, then let the pipeline empty
  task automatic settle();
    int unsigned waited;
    waited = 0;
    s_valid <= 1'b0;
    @(posedge clk);
    while (expected_means.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_means.size() != 0) begin
      $error("%0d expected results never arrived", expected_means.size());
      failures++;
      expected_means.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // one grid setting and a run of cells; the first cell opens a frame if restart
  // is set, and noisy phases sprinkle stray frame starts
  task automatic run_phase(input logic [CFG_DATA_W-1:0] rows_cfg,
                           input logic [CFG_DATA_W-1:0] cols_cfg,
                           input int unsigned cells, input bit restart, input bit noisy,
                           input int unsigned pause_at, input int unsigned hold_at);
    logic opens;
    settle();
    write_reg(REG_GRID_ROWS, rows_cfg);
    write_reg(REG_GRID_COLS, cols_cfg);
    pace_mode = pace_e'(phase_count % 3);
    phase_count++;
    for (int unsigned n = 0; n < cells; n++) begin
      if (pause_at != 0 && n == pause_at) begin
        settle();
      end
      if (hold_at != 0 && n == hold_at) begin
        hold_req = 1'b1;
      end
      opens = (n == 0 && restart) || (noisy && $urandom_range(0, 99) < NOISE_PCT);
      offer_cell(draw_cell(), opens, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // directed table
  // ---------------------------------------------------------------------------
  plan_row_t directed_plan[$];

  function automatic void plan_write(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
    plan_row_t row;
    row = '{kind: ROW_WRITE, idx: idx, value: VALUE_W'(data), start: 1'b0,
            typed: 1'b0, want: '0};
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_cell(input logic [VALUE_W-1:0] value, input logic start,
                                    input logic typed, input stencil_mean_t want);
    plan_row_t row;
    row = '{kind: ROW_CELL, idx: '0, value: value, start: start, typed: typed, want: want};
    directed_plan.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned rr, cc;
    plan_row_t   row;

    // both registers below their range: the block works on a 3 x 3 grid
    plan_write(REG_GRID_ROWS, '0);
    plan_write(REG_GRID_COLS, CFG_DATA_W'(2));
    // all cells at full scale: the edges collapse to zero, so the only interior
    // mean is the centre over five, exactly a fifth of full scale
    for (int unsigned i = 0; i < 9; i++) begin
      if (i == 7) begin
        plan_cell('1, 1'b0, 1'b1, '{center_row: 1, center_col: 1,
                                   average: 48'h3333_3333_3333, frame_last: 1'b1});
      end else begin
        plan_cell('1, (i == 0), 1'b0, '0);
      end
    end
    // second frame without a start flag, relying on the wrap; centre zero
    for (int unsigned i = 0; i < 9; i++) begin
      if (i == 7) begin
        plan_cell('1, 1'b0, 1'b1, '{center_row: 1, center_col: 1,
                                   average: '0, frame_last: 1'b1});
      end else begin
        plan_cell((i == 4) ? '0 : '1, 1'b0, 1'b0, '0);
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    pace_mode   = PACE_SEND_LIGHT;
    phase_count = 1;
    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.kind == ROW_WRITE) begin
        settle();
        write_reg(row.idx, row.value[CFG_DATA_W-1:0]);
      end else begin
        offer_cell(row.value, row.start, row.typed, row.want);
      end
    end

    // random content with stray frame starts, and a pause mid-frame in the first phase
    run_phase(6, 9, 40, 1'b1, 1'b1, 20, 0);
    run_phase(3, 5, 30, 1'b1, 1'b1, 0, 0);
    run_phase(4, 3, 36, 1'b1, 1'b1, 0, 0);
    // long output stall while cells keep coming: the pipeline fills and holds
    run_phase(9, 12, 108, 1'b1, 1'b0, 0, 20);
    // tallest grid: rows written all ones clamp to the maximum, narrowest width
    run_phase('1, 3, 24, 1'b1, 1'b0, 0, 0);
    // widest grid: the upper data bits are dropped, leaving the maximum width
    run_phase(3, 13'h1C00, 24, 1'b1, 1'b0, 0, 0);
    // stop partway through row 4, column 5 ...
    run_phase(7, 10, 45, 1'b1, 1'b0, 0, 0);
    // ... then narrow the grid so that position falls outside it
    run_phase(7, 4, 40, 1'b0, 1'b0, 0, 0);
    // out-of-range small registers once more, now on random data
    run_phase(2, 1, 30, 1'b1, 1'b1, 0, 0);
    for (int unsigned p = 0; p < 2; p++) begin
      rr = $urandom_range(3, 6);
      cc = $urandom_range(3, 8);
      run_phase(CFG_DATA_W'(rr), CFG_DATA_W'(cc), rr * cc + 3, 1'b1, 1'b1, 0, 0);
    end

    settle();
    $display("covered %0d cells and %0d interior results across %0d register writes",
             cells_taken, results_taken, writes_done);
    $display("grids from 3 x 3 to 4096 rows and 1024 columns, wraps, restarts, long stall");
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
